>>> rtl/itoa_pkg.sv
// shared constants and types for the integer to ascii converter
`timescale 1ns / 1ps

package itoa_pkg;

   localparam int StoreDepth = 10;
   localparam int StoreAw    = $clog2(StoreDepth);
   localparam int MaxDigits  = 11;

   // q = (x * recip) >> 35 gives x / 10 or x / 16 exactly for any 32-bit x
   localparam logic [31:0] DecRecip = 32'hCCCC_CCCD;
   localparam logic [31:0] HexRecip = 32'h8000_0000;
   localparam int          QuotLsb  = 35;

   localparam logic [6:0] AsciiZero  = 7'h30;
   localparam logic [6:0] AsciiLowA  = 7'h61;
   localparam logic [6:0] AsciiMinus = 7'h2D;
   localparam logic [3:0] DecBase    = 4'd10;

   typedef struct packed {
      logic        done;
      logic [31:0] quot;
      logic [3:0]  digit;
   } itoa_step_type;

endpackage

>>> rtl/itoa_if.sv
// valid/ready channels for the converter input and output items
`timescale 1ns / 1ps

interface itoa_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               base_hex;
   logic [4:0]         room;

   modport source (output valid, value, base_hex, room, input ready);
   modport sink (input valid, value, base_hex, room, output ready);
endinterface

interface itoa_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] ch;
   logic       is_empty;
   logic       last;

   modport source (output valid, ch, is_empty, last, input ready);
   modport sink (input valid, ch, is_empty, last, output ready);
endinterface

>>> rtl/itoa_digit_unit.sv
// shared divide-by-base unit: one quotient and one remainder digit per step
`timescale 1ns / 1ps

module itoa_digit_unit import itoa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          go,
   input  logic          hex,
   input  logic [31:0]   x,
   output itoa_step_type step
);

   logic [31:0] recip;
   logic [63:0] prod_in;
   logic [63:0] prod_ff;
   logic [31:0] x_ff;
   logic        hex_ff;
   logic        done_ff;
   logic [3:0]  q_low;
   logic [3:0]  q_times_ten;

   assign recip   = hex ? HexRecip : DecRecip;
   assign prod_in = 64'(x) * 64'(recip);

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= go;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         prod_ff <= prod_in;
         x_ff    <= x;
         hex_ff  <= hex;
      end
   end

   // remainder is below the base, so the low four bits are enough
   assign q_low       = prod_ff[QuotLsb+3:QuotLsb];
   assign q_times_ten = (q_low << 3) + (q_low << 1);

   always_comb begin
      step.done  = done_ff;
      step.quot  = 32'(prod_ff[63:QuotLsb]);
      step.digit = hex_ff ? x_ff[3:0] : (x_ff[3:0] - q_times_ten);
   end

endmodule

>>> rtl/integer_to_ascii_dec_hex.sv
// integer to ascii text converter, decimal or lower-case hex, top level
//
//   port      dir   payload                         meaning
//   req_bus   in    value[31:0] base_hex room[4:0]  integer, base, room left
//   rsp_bus   out   ch[6:0] is_empty last           one character per item
//
// the item is accepted, the divider is loaded, then each digit (up to 10
// decimal, up to 8 hex) comes from the shared multiply-by-reciprocal unit,
// then the characters go out one per item, up to 11 in all
// req ready only while idle; the final item may wait in the output register
// while the next input is taken. rsp stalls hold the character loop
// synchronous active-high reset clears the sequencer and the output valid
`timescale 1ns / 1ps

module integer_to_ascii_dec_hex import itoa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   itoa_req_if.sink          req_bus,
   itoa_rsp_if.source        rsp_bus
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_STEP = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [31:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic        hex_ff, hex_in;
   logic        zero_ff, zero_in;
   logic [3:0]  limit_ff, limit_in;
   logic [3:0]  ndig_ff, ndig_in;
   logic [3:0]  pos_ff, pos_in;
   logic [3:0]  store_ff [StoreDepth];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [6:0]  ch_ff, ch_in;
   logic        empty_ff, empty_in;
   logic        last_ff, last_in;

   logic          accept;
   logic          out_free;
   logic          load_out;
   logic          store_wr;
   logic          unit_go;
   logic [31:0]   unit_x;
   itoa_step_type step;
   logic [4:0]    room_m1;
   logic [31:0]   value_u;
   logic          neg_req;
   logic [3:0]    total;
   logic [3:0]    count;
   logic [3:0]    dpos;
   logic [StoreAw-1:0] idx;
   logic [3:0]    dval;
   logic [6:0]    dchar;

   itoa_digit_unit u_digit (
      .clock (clock),
      .reset (reset),
      .go    (unit_go),
      .hex   (hex_ff),
      .x     (unit_x),
      .step  (step)
   );

   assign accept         = req_bus.valid && req_bus.ready;
   assign req_bus.ready  = (state_ff == ST_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_bus.ready;
   assign value_u        = $unsigned(req_bus.value);
   assign neg_req        = !req_bus.base_hex && value_u[31];
   assign room_m1        = req_bus.room - 5'd1;

   assign total = ndig_ff + {3'b000, neg_ff};
   assign count = (total < limit_ff) ? total : limit_ff;
   assign dpos  = pos_ff - {3'b000, neg_ff};
   assign idx   = StoreAw'(ndig_ff - 4'd1 - dpos);
   assign dval  = (idx < StoreAw'(StoreDepth)) ? store_ff[idx] : 4'd0;
   assign dchar = (dval >= DecBase) ? (AsciiLowA + 7'(dval - DecBase))
                                    : (AsciiZero + 7'(dval));

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      hex_in       = hex_ff;
      zero_in      = zero_ff;
      limit_in     = limit_ff;
      ndig_in      = ndig_ff;
      pos_in       = pos_ff;
      unit_go      = 1'b0;
      unit_x       = mag_ff;
      store_wr     = 1'b0;
      load_out     = 1'b0;
      ch_in        = ch_ff;
      empty_in     = empty_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hex_in  = req_bus.base_hex;
               neg_in  = neg_req;
               zero_in = (value_u == 32'd0);
               mag_in  = neg_req ? (~value_u + 32'd1) : value_u;
               ndig_in = 4'd0;
               pos_in  = 4'd0;
               if (req_bus.room == 5'd0) begin
                  limit_in = 4'd0;
               end else if (room_m1 > 5'(MaxDigits)) begin
                  limit_in = 4'(MaxDigits);
               end else begin
                  limit_in = room_m1[3:0];
               end
               state_in = (value_u == 32'd0) ? ST_EMIT : ST_LOAD;
            end
         end
         ST_LOAD: begin
            unit_go  = 1'b1;
            unit_x   = mag_ff;
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (step.done) begin
               store_wr = 1'b1;
               ndig_in  = ndig_ff + 4'd1;
               mag_in   = step.quot;
               if (step.quot != 32'd0 && ndig_ff != 4'(StoreDepth - 1)) begin
                  unit_go = 1'b1;
                  unit_x  = step.quot;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               priority if (zero_ff) begin
                  ch_in    = AsciiZero;
                  empty_in = 1'b0;
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end else if (count == 4'd0) begin
                  ch_in    = 7'd0;
                  empty_in = 1'b1;
                  last_in  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  ch_in    = (neg_ff && pos_ff == 4'd0) ? AsciiMinus : dchar;
                  empty_in = 1'b0;
                  last_in  = (pos_ff + 4'd1 == count);
                  pos_in   = pos_ff + 4'd1;
                  if (pos_ff + 4'd1 == count) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ndig_ff      <= 4'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ndig_ff      <= ndig_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      hex_ff   <= hex_in;
      zero_ff  <= zero_in;
      limit_ff <= limit_in;
      pos_ff   <= pos_in;
      if (load_out) begin
         ch_ff    <= ch_in;
         empty_ff <= empty_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr) begin
         store_ff[StoreAw'(ndig_ff)] <= step.digit;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.ch       = ch_ff;
   assign rsp_bus.is_empty = empty_ff;
   assign rsp_bus.last     = last_ff;

`ifndef SYNTHESIS
   a_done_in_step: assert property (@(posedge clock) disable iff (reset)
      step.done |-> state_ff == ST_STEP)
      else $error("divider result outside the digit loop");

   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_LOAD || state_ff == ST_EMIT)
      else $error("accepted item did not start conversion");

   a_ndig_bound: assert property (@(posedge clock) disable iff (reset)
      ndig_ff <= 4'(StoreDepth))
      else $error("digit count beyond store depth");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && empty_ff |-> last_ff)
      else $error("empty item not marked last");

   a_zero_no_digits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && zero_ff |-> ndig_ff == 4'd0)
      else $error("zero value holds digits");
`endif

endmodule
